// ----- src/mbrx_pkg.sv -----
// Shared types, codes and CRC-16 helper for the Modbus RTU response receiver.
// No dependencies.
package mbrx_pkg;

  typedef enum logic [1:0] {
    FN_START  = 2'd0,
    FN_BYTE   = 2'd1,
    FN_POLL   = 2'd2,
    FN_UNUSED = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RECV    = 2'd1,
    ST_DONE    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_SLAVE_ADDR  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FUNC_CODE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WORDS       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WRITE_ECHO  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RETRY_LIMIT = 3'd4;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD = 16'h0000;
  localparam logic [7:0]  WRITE_ECHO_FUNC = 8'h10;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/modbus_rtu_response_receiver.sv -----
// Modbus RTU master-side response receiver: one item in, one or more results out.
// A start, poll or ignored item goes straight to its response; a received byte is written, then
// the slave byte is read and checked, and the function byte too once it is in the store; when the
// byte completes a frame the CRC check reads back all expected_length bytes, bounded by the single
// read port of the frame memory feeding the byte-wide CRC unit. Each payload byte is read, then
// registered to the output unless the output stalls. The frame memory is a circular buffer;
// dropping the oldest byte only advances its head. Depends on mbrx_pkg and mbrx_crc.
module modbus_rtu_response_receiver
  import mbrx_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [7:0]         payload_byte_o,
  output logic               payload_valid_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned StoreDepth = 5 + 2 * MAX_WORDS;
  localparam int unsigned AW = $clog2(StoreDepth);
  localparam int unsigned FW = $clog2(StoreDepth + 1);
  localparam int unsigned CW = (FW > 4) ? FW : 4;
  localparam int unsigned KW = $clog2(2 * MAX_WORDS + 1);
  localparam int unsigned WW = $clog2(MAX_WORDS + 1) > 6 ? $clog2(MAX_WORDS + 1) : 6;
  localparam int unsigned MemSize = 2 ** AW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_CHK0, S_CHK1, S_CRC, S_CRC_TAIL, S_CRC_CHK,
    S_PAY_RD, S_PAY_OUT, S_RESP
  } state_e;

  // configuration
  logic [7:0] slave_q, fcode_q;
  logic [5:0] words_q;
  logic       echo_q;
  logic [3:0] limit_q;

  state_e      state_q, state_d;
  status_e     phase_q, phase_d;
  logic [FW-1:0] fill_q, fill_d, idx_q, idx_d;
  logic [AW-1:0] head_q, head_d;
  logic [4:0]    polls_q, polls_d;
  logic [KW-1:0] k_q, k_d;
  logic          feed_q, feed_d;

  logic       ov_q, ov_d, opv_q, opv_d, olast_q, olast_d;
  logic [1:0] ostat_q, ostat_d;
  logic [7:0] obyte_q, obyte_d;

  logic [7:0]    mem [MemSize];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  logic [WW-1:0] words_w;
  logic [CW-1:0] expect_c, fill_c;
  logic [KW-1:0] n_c;
  logic [7:0]    fexp_c;
  logic          out_free, crc_good, crc_init;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= 8'd1;
      fcode_q <= 8'd3;
      words_q <= 6'd1;
      echo_q  <= 1'b0;
      limit_q <= 4'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SLAVE_ADDR:  slave_q <= cfg_data_i;
        REG_FUNC_CODE:   fcode_q <= cfg_data_i;
        REG_WORDS:       words_q <= cfg_data_i[5:0];
        REG_WRITE_ECHO:  echo_q  <= cfg_data_i[0];
        REG_RETRY_LIMIT: limit_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // saturate word count to the store size
  assign words_w  = (WW'(words_q) > WW'(MAX_WORDS)) ? WW'(MAX_WORDS) : WW'(words_q);
  assign expect_c = echo_q ? CW'(8) : CW'(5) + CW'({words_w, 1'b0});
  assign n_c      = KW'({words_w, 1'b0});
  assign fexp_c   = echo_q ? WRITE_ECHO_FUNC : fcode_q;
  assign fill_c   = CW'(fill_q);
  assign out_free = !ov_q || !out_stall_i;
  assign crc_init = (state_q == S_CHK1);

  always_comb begin
    case (state_q)
      S_RD0:               rd_addr = head_q;
      S_CHK0:              rd_addr = AW'(head_q + AW'(1));
      S_CRC:               rd_addr = AW'(head_q + AW'(idx_q));
      S_PAY_RD, S_PAY_OUT: rd_addr = AW'(head_q + AW'(3) + AW'(k_q));
      default:             rd_addr = head_q;
    endcase
  end

  assign wr_addr = AW'(head_q + AW'(fill_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_byte_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  mbrx_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (crc_init),
    .en_i   (feed_q),
    .data_i (rd_data_q),
    .good_o (crc_good)
  );

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    head_d  = head_q;
    polls_d = polls_q;
    k_d     = k_q;
    feed_d  = 1'b0;
    wr_en   = 1'b0;
    ov_d    = ov_q && out_stall_i;
    opv_d   = opv_q;
    olast_d = olast_q;
    ostat_d = ostat_q;
    obyte_d = obyte_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RESP;
          case (func_e'(func_i))
            FN_START: begin
              fill_d  = '0;
              polls_d = '0;
              phase_d = ST_RECV;
            end
            FN_BYTE: begin
              if (phase_q == ST_RECV) begin
                if (fill_q >= FW'(StoreDepth)) begin
                  fill_d = '0;
                end else begin
                  wr_en   = 1'b1;
                  fill_d  = FW'(fill_q + FW'(1));
                  state_d = S_RD0;
                end
              end
            end
            FN_POLL: begin
              if (phase_q == ST_RECV) begin
                if (polls_q > {1'b0, limit_q}) begin
                  phase_d = ST_TIMEOUT;
                end else begin
                  polls_d = 5'(polls_q + 5'd1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD0: state_d = S_CHK0;
      S_CHK0: begin
        if (rd_data_q != slave_q) begin
          fill_d  = '0;
          state_d = S_RESP;
        end else if (fill_q < FW'(2)) begin
          state_d = S_RESP;
        end else begin
          state_d = S_CHK1;
        end
      end
      S_CHK1: begin
        state_d = S_RESP;
        if (rd_data_q != fexp_c) begin
          head_d = AW'(head_q + AW'(1));
          fill_d = FW'(fill_q - FW'(1));
        end else if (fill_c > expect_c) begin
          fill_d = '0;
        end else if (fill_c == expect_c) begin
          idx_d   = '0;
          state_d = S_CRC;
        end
      end
      S_CRC: begin
        feed_d = 1'b1;
        idx_d  = FW'(idx_q + FW'(1));
        if (CW'(idx_q) == CW'(expect_c - CW'(1))) begin
          state_d = S_CRC_TAIL;
        end
      end
      S_CRC_TAIL: state_d = S_CRC_CHK;
      S_CRC_CHK: begin
        state_d = S_RESP;
        if (crc_good) begin
          phase_d = ST_DONE;
          fill_d  = '0;
          if (!echo_q && (n_c != '0)) begin
            k_d     = '0;
            state_d = S_PAY_RD;
          end
        end else begin
          head_d = AW'(head_q + AW'(1));
          fill_d = FW'(fill_q - FW'(1));
        end
      end
      S_PAY_RD: state_d = S_PAY_OUT;
      S_PAY_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ostat_d = ST_DONE;
          obyte_d = rd_data_q;
          opv_d   = 1'b1;
          olast_d = (k_q == KW'(n_c - KW'(1)));
          if (olast_d) begin
            state_d = S_IDLE;
          end else begin
            k_d     = KW'(k_q + KW'(1));
            state_d = S_PAY_RD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ostat_d = phase_q;
          obyte_d = 8'h00;
          opv_d   = 1'b0;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= ST_IDLE;
      fill_q  <= '0;
      head_q  <= '0;
      polls_q <= '0;
      idx_q   <= '0;
      k_q     <= '0;
      feed_q  <= 1'b0;
      ov_q    <= 1'b0;
      ostat_q <= '0;
      obyte_q <= '0;
      opv_q   <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fill_q  <= fill_d;
      head_q  <= head_d;
      polls_q <= polls_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      feed_q  <= feed_d;
      ov_q    <= ov_d;
      ostat_q <= ostat_d;
      obyte_q <= obyte_d;
      opv_q   <= opv_d;
      olast_q <= olast_d;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = ov_q;
  assign status_o        = ostat_q;
  assign payload_byte_o  = obyte_q;
  assign payload_valid_o = opv_q;
  assign last_o          = olast_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(StoreDepth))
    else $error("frame fill count beyond store depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted without starting work");

  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (status_o == ST_DONE))
    else $error("payload byte outside an accepted frame");

endmodule

// ----- src/mbrx_crc.sv -----
// Byte-wide CRC-16 accumulator, reused for every frame check.
// Depends on mbrx_pkg.
module mbrx_crc
  import mbrx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       init_i,
  input  logic       en_i,
  input  logic [7:0] data_i,
  output logic       good_o
);

  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (init_i) begin
      crc_d = CRC_INIT;
    end else if (en_i) begin
      crc_d = crc16_byte(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign good_o = (crc_q == CRC_GOOD);

endmodule
